/* hdl/cba_pkg.sv */
// Shared sizes, codes and controller/datapath interface types for the
// contiguous block allocator. No dependencies; used by every module.
`timescale 1ns / 1ps

package cba_pkg;

  // Array geometry.
  localparam int NUM_BLOCKS = 64;
  localparam int UNIT_SIZE  = 4;   // bytes per block, a power of two
  localparam int OWNER_BITS = 8;

  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int UNIT_SHIFT = $clog2(UNIT_SIZE);

  // Port field widths.
  localparam int OPCODE_W = 1;
  localparam int OWNER_W  = 8;
  localparam int REQ_W    = 16;
  localparam int NEED_W   = REQ_W + 1;
  localparam int START_W  = 6;
  localparam int STRAT_W  = 2;

  // Register port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_STRATEGY_SEL = 1'b0;  // word select bit of the strategy register

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  // Placement strategies.
  localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

  // Result status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT_PTR,
    DP_INIT_ZERO,
    DP_FREE_STEP,
    DP_NEXT_STEP,
    DP_RUN_STEP,
    DP_PLACE_INIT,
    DP_PLACE_STEP,
    DP_RESULT
  } dp_op_t;

  // How the result register is filled.
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_ZERO,
    RES_FREE,
    RES_PLACED
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    logic      largest;   // worst fit keeps the largest run
    logic      upd_ptr;   // move the next-fit pointer past the placed run
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic need_zero;
    logic need_big;
    logic free_done;
    logic next_hit;
    logic scan_last;
    logic run_done;
    logic pick_valid;
    logic place_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/cba_datapath.sv */
// Datapath of the contiguous block allocator: free map, owner memory,
// scan counters, run tracking and the result register. Uses cba_pkg.
`timescale 1ns / 1ps

module cba_datapath
  import cba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [OWNER_W-1:0]  owner_id,
  input  logic [REQ_W-1:0]    request_size,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                status,
  output logic [START_W-1:0]  start_block
);

  // Control state.
  logic [NUM_BLOCKS-1:0] free_map;
  logic [BLK_W-1:0]      next_ptr;
  logic                  found;
  logic                  pick_valid;
  logic                  rd_valid;
  logic                  res_valid;

  // Item and scan payload.
  logic [OPCODE_W-1:0]   item_opcode;
  logic [OWNER_BITS-1:0] item_owner;
  logic [CNT_W-1:0]      need;
  logic                  need_zero;
  logic                  need_big;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      run_len;
  logic [BLK_W-1:0]      run_start;
  logic [BLK_W-1:0]      pick_start;
  logic [CNT_W-1:0]      pick_len;
  logic [BLK_W-1:0]      rd_idx;
  logic [OWNER_BITS-1:0] rdata;
  logic                  res_status;
  logic [BLK_W-1:0]      res_start;

  // Owner tag memory; tags of free blocks are never looked at.
  logic [OWNER_BITS-1:0] owner_mem [NUM_BLOCKS];

  logic [NEED_W-1:0] need_full;
  logic              idx_in;
  logic [BLK_W-1:0]  blk;
  logic              cur_free;
  logic [CNT_W-1:0]  len_inc;
  logic              next_hit;
  logic [CNT_W-1:0]  hit_start;
  logic              run_better;
  logic [SUM_W-1:0]  end_sum;
  logic              owner_match;

  // Blocks needed: byte size rounded up to whole blocks.
  assign need_full = (NEED_W'(request_size) + NEED_W'(UNIT_SIZE - 1)) >> UNIT_SHIFT;

  // Scan position and run arithmetic.
  assign idx_in    = idx < CNT_W'(NUM_BLOCKS);
  assign blk       = idx[BLK_W-1:0];
  assign cur_free  = idx_in && free_map[blk];
  assign len_inc   = run_len + CNT_W'(1);
  assign next_hit  = cur_free && (len_inc == need);
  assign hit_start = idx + CNT_W'(1) - need;
  assign end_sum   = SUM_W'(pick_start) + SUM_W'(need);

  // A closed run qualifies when it fits and beats the current pick.
  assign run_better = (run_len >= need) && (run_len != '0) &&
                      (!pick_valid || (cmd.largest ? (run_len > pick_len)
                                                   : (run_len < pick_len)));

  assign owner_match = rd_valid && !free_map[rd_idx] && (rdata == item_owner);

  // Status back to the controller.
  always_comb begin
    sts.opcode     = item_opcode;
    sts.need_zero  = need_zero;
    sts.need_big   = need_big;
    sts.free_done  = rd_valid && (rd_idx == BLK_W'(NUM_BLOCKS - 1));
    sts.next_hit   = next_hit;
    sts.scan_last  = idx == CNT_W'(NUM_BLOCKS - 1);
    sts.run_done   = !idx_in;
    sts.pick_valid = pick_valid;
    sts.place_last = len_inc == need;
    sts.out_free   = !res_valid || !out_stall;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map   <= '1;
      next_ptr   <= '0;
      found      <= 1'b0;
      pick_valid <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      case (cmd.op)
        DP_LOAD, DP_INIT_PTR, DP_INIT_ZERO: begin
          found      <= 1'b0;
          pick_valid <= 1'b0;
          rd_valid   <= 1'b0;
        end
        DP_FREE_STEP: begin
          rd_valid <= idx_in;
          if (owner_match) begin
            free_map[rd_idx] <= 1'b1;
            found            <= 1'b1;
          end
        end
        DP_NEXT_STEP: begin
          if (next_hit) pick_valid <= 1'b1;
        end
        DP_RUN_STEP: begin
          if (!cur_free && run_better) pick_valid <= 1'b1;
        end
        DP_PLACE_INIT: begin
          if (cmd.upd_ptr) begin
            next_ptr <= (end_sum >= SUM_W'(NUM_BLOCKS)) ? '0 : end_sum[BLK_W-1:0];
          end
        end
        DP_PLACE_STEP: begin
          free_map[blk] <= 1'b0;
        end
        default: begin
          rd_valid <= 1'b0;
        end
      endcase
    end
  end

  // Result register valid: loaded by the controller, cleared on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == DP_RESULT) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Item, scan and result payload.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        item_opcode <= opcode;
        item_owner  <= owner_id[OWNER_BITS-1:0];
        need        <= need_full[CNT_W-1:0];
        need_zero   <= need_full == '0;
        need_big    <= need_full > NEED_W'(NUM_BLOCKS);
      end
      DP_INIT_PTR: begin
        idx     <= CNT_W'(next_ptr);
        run_len <= '0;
      end
      DP_INIT_ZERO: begin
        idx     <= '0;
        run_len <= '0;
      end
      DP_FREE_STEP: begin
        if (idx_in) idx <= idx + CNT_W'(1);
        rd_idx <= blk;
      end
      DP_NEXT_STEP: begin
        idx     <= idx + CNT_W'(1);
        run_len <= cur_free ? len_inc : '0;
        if (next_hit) pick_start <= hit_start[BLK_W-1:0];
      end
      DP_RUN_STEP: begin
        if (idx_in) idx <= idx + CNT_W'(1);
        if (cur_free) begin
          run_len <= len_inc;
          if (run_len == '0) run_start <= blk;
        end else begin
          run_len <= '0;
          if (run_better) begin
            pick_start <= run_start;
            pick_len   <= run_len;
          end
        end
      end
      DP_PLACE_INIT: begin
        idx     <= CNT_W'(pick_start);
        run_len <= '0;
      end
      DP_PLACE_STEP: begin
        idx     <= idx + CNT_W'(1);
        run_len <= len_inc;
      end
      DP_RESULT: begin
        case (cmd.res_kind)
          RES_ZERO: begin
            res_status <= STAT_OK;
            res_start  <= '0;
          end
          RES_FREE: begin
            res_status <= found ? STAT_OK : STAT_FAIL;
            res_start  <= '0;
          end
          RES_PLACED: begin
            res_status <= STAT_OK;
            res_start  <= pick_start;
          end
          default: begin
            res_status <= STAT_FAIL;
            res_start  <= '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Owner memory: one write port for placing, one registered read port for freeing.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PLACE_STEP) owner_mem[blk] <= item_owner;
    if (cmd.op == DP_FREE_STEP) rdata <= owner_mem[blk];
  end

  assign out_valid   = res_valid;
  assign status      = res_status;
  assign start_block = START_W'(res_start);

endmodule

/* hdl/cba_ctrl.sv */
// Controller of the contiguous block allocator: sequences scans, placement
// and result loading through datapath commands. Uses cba_pkg.
`timescale 1ns / 1ps

module cba_ctrl
  import cba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [STRAT_W-1:0] strategy,
  input  dp_sts_t            sts,
  output dp_cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_FREE_SCAN,
    S_NEXT_FWD,
    S_NEXT_WRAP,
    S_NEXT_ALL,
    S_RUN_SCAN,
    S_RUN_CHECK,
    S_PLACE_INIT,
    S_PLACE,
    S_RESULT
  } state_t;

  state_t    state, state_next;
  res_kind_t res_kind, res_kind_next;

  // Next state and datapath command.
  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    cmd.op        = DP_NOP;
    cmd.largest   = strategy == STRAT_WORST;
    cmd.upd_ptr   = strategy == STRAT_NEXT;
    cmd.res_kind  = res_kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.opcode == OP_FREE) begin
          cmd.op     = DP_INIT_ZERO;
          state_next = S_FREE_SCAN;
        end else if (sts.need_zero) begin
          res_kind_next = RES_ZERO;
          state_next    = S_RESULT;
        end else if (sts.need_big) begin
          res_kind_next = RES_FAIL;
          state_next    = S_RESULT;
        end else if (strategy == STRAT_NEXT) begin
          cmd.op     = DP_INIT_PTR;
          state_next = S_NEXT_FWD;
        end else if (strategy == STRAT_BEST || strategy == STRAT_WORST) begin
          cmd.op     = DP_INIT_ZERO;
          state_next = S_RUN_SCAN;
        end else begin
          res_kind_next = RES_FAIL;
          state_next    = S_RESULT;
        end
      end
      S_FREE_SCAN: begin
        cmd.op = DP_FREE_STEP;
        if (sts.free_done) begin
          res_kind_next = RES_FREE;
          state_next    = S_RESULT;
        end
      end
      S_NEXT_FWD: begin
        cmd.op = DP_NEXT_STEP;
        if (sts.next_hit) begin
          state_next = S_PLACE_INIT;
        end else if (sts.scan_last) begin
          state_next = S_NEXT_WRAP;
        end
      end
      S_NEXT_WRAP: begin
        cmd.op     = DP_INIT_ZERO;
        state_next = S_NEXT_ALL;
      end
      S_NEXT_ALL: begin
        cmd.op = DP_NEXT_STEP;
        if (sts.next_hit) begin
          state_next = S_PLACE_INIT;
        end else if (sts.scan_last) begin
          res_kind_next = RES_FAIL;
          state_next    = S_RESULT;
        end
      end
      S_RUN_SCAN: begin
        cmd.op = DP_RUN_STEP;
        if (sts.run_done) state_next = S_RUN_CHECK;
      end
      S_RUN_CHECK: begin
        if (sts.pick_valid) begin
          state_next = S_PLACE_INIT;
        end else begin
          res_kind_next = RES_FAIL;
          state_next    = S_RESULT;
        end
      end
      S_PLACE_INIT: begin
        cmd.op     = DP_PLACE_INIT;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.op = DP_PLACE_STEP;
        if (sts.place_last) begin
          res_kind_next = RES_PLACED;
          state_next    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.op     = DP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered result kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_kind <= RES_FAIL;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

  assign in_stall = state != S_IDLE;

endmodule

/* hdl/contiguous_block_allocator_top.sv */
// Top level of the contiguous block allocator: register port, controller
// and datapath. Uses cba_pkg, cba_ctrl and cba_datapath.
//
//   Channel  Direction  Handshake         Payload
//   in       input      in_valid/in_stall  opcode, owner_id, request_size
//   out      output     out_valid/out_stall status, start_block
//   cfg      input      APB write/read     strategy at byte address 0
//
// Free: one owner memory read per block.
// Next fit, best fit and worst fit: the free map is scanned one block a cycle
// and the placed run is written one block a cycle through the owner memory.
// Reset marks every block free, zeroes the next-fit pointer and selects next
// fit; there is no clearing pass. A new item is taken only when the previous
// one is finished; a result waits in the output register while out_stall is high.
`timescale 1ns / 1ps

module contiguous_block_allocator_top
  import cba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [OWNER_W-1:0]  owner_id,
  input  logic [REQ_W-1:0]    request_size,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic [START_W-1:0]  start_block,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [STRAT_W-1:0] strategy;
  logic               cfg_write;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  // Configuration register transfer.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= STRAT_NEXT;
    end else if (cfg_write && paddr[2] == REG_STRATEGY_SEL) begin
      strategy <= pwdata[STRAT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_STRATEGY_SEL) ? DATA_W'(strategy) : '0;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .strategy (strategy),
    .sts      (sts),
    .cmd      (cmd)
  );

  cba_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .owner_id     (owner_id),
    .request_size (request_size),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .start_block  (start_block)
  );

  // A failed item never reports a start block.
  a_fail_zero_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FAIL |-> start_block == '0)
    else $error("failed result carries a nonzero start block");

  // An accepted item keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted item");

  // A new result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_RESULT |-> !out_valid || !out_stall)
    else $error("result register loaded while holding a stalled result");

endmodule
